// ===== design/mqpf_pkg.sv =====
// Shared constants, types and helpers for the multi-queue priority FIFO core.
// Depends on nothing; every other design file refers to it by scoped names.
package mqpf_pkg;

    localparam int NUM_QUEUES  = 5;
    localparam int NUM_LEVELS  = 10;
    localparam int LIST_DEPTH  = 16;
    localparam int ID_BITS     = 16;

    localparam int FIFO_COUNT  = NUM_QUEUES * NUM_LEVELS;
    localparam int STORE_DEPTH = FIFO_COUNT * LIST_DEPTH;

    localparam int FIFO_BITS   = (FIFO_COUNT > 1) ? $clog2(FIFO_COUNT) : 1;
    localparam int STORE_ABITS = $clog2(STORE_DEPTH);
    localparam int LVL_BITS    = $clog2(NUM_LEVELS);
    localparam int PTR_BITS    = $clog2(LIST_DEPTH);
    localparam int CNT_BITS    = $clog2(LIST_DEPTH + 1);

    localparam int FUNC_BITS   = 1;
    localparam int QSEL_BITS   = 3;
    localparam int PRI_BITS    = 4;
    localparam int STATUS_BITS = 2;
    localparam int OUT_ID_BITS = 16;

    localparam logic [FUNC_BITS-1:0] FUNC_PUSH = 1'b0;
    localparam logic [FUNC_BITS-1:0] FUNC_POP  = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_PUSH_OK = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_POP_OK  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_REJECT  = 2'd3;

    // Read pointer and fill level of one FIFO.
    typedef struct packed {
        logic [PTR_BITS-1:0] head;
        logic [CNT_BITS-1:0] count;
    } t_desc;

    typedef struct packed {
        logic                 en;
        logic [FIFO_BITS-1:0] addr;
        t_desc                desc;
    } t_desc_wr;

    typedef struct packed {
        logic                   en;
        logic [STORE_ABITS-1:0] addr;
        logic [ID_BITS-1:0]     data;
    } t_store_wr;

    // Low bits of an entry number as carried on the result port.
    function automatic logic [OUT_ID_BITS-1:0] to_out_id(input logic [ID_BITS-1:0] v);
        logic [ID_BITS+OUT_ID_BITS-1:0] t;
        t = {{OUT_ID_BITS{1'b0}}, v};
        return t[OUT_ID_BITS-1:0];
    endfunction

endpackage

// ===== design/mqpf_desc_mem.sv =====
// Descriptor table: head pointer and fill level for every queue/level FIFO.
// Per-entry valid bits make unwritten entries read as empty. Uses mqpf_pkg.
module mqpf_desc_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [mqpf_pkg::FIFO_BITS-1:0] i_rd_addr,
    output mqpf_pkg::t_desc               o_rd_desc,
    input  mqpf_pkg::t_desc_wr            i_wr
);

    mqpf_pkg::t_desc                  r_mem [mqpf_pkg::FIFO_COUNT];
    logic [mqpf_pkg::FIFO_COUNT-1:0]  r_valid;
    mqpf_pkg::t_desc                  r_rd_desc;
    logic                             r_rd_valid;

    // valid bits and read-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.desc;
        end
        if (i_rd_en) begin
            r_rd_desc <= r_mem[i_rd_addr];
        end
    end

    // unwritten entry reads as an empty FIFO at slot zero
    assign o_rd_desc = r_rd_valid ? r_rd_desc : '0;

endmodule

// ===== design/mqpf_entry_mem.sv =====
// Entry store: the arrival numbers held in every FIFO, one slot row per FIFO.
// Single write port, single registered read port. Uses mqpf_pkg.
module mqpf_entry_mem (
    input  logic                            i_clk,
    input  mqpf_pkg::t_store_wr             i_wr,
    input  logic                            i_rd_en,
    input  logic [mqpf_pkg::STORE_ABITS-1:0] i_rd_addr,
    output logic [mqpf_pkg::ID_BITS-1:0]    o_rd_data
);

    logic [mqpf_pkg::ID_BITS-1:0] r_mem [mqpf_pkg::STORE_DEPTH];
    logic [mqpf_pkg::ID_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/multi_queue_priority_fifo_core.sv =====
// Multi-queue stable priority FIFO core: sequencer, arrival counter, result register.
// Instantiates mqpf_desc_mem and mqpf_entry_mem; uses mqpf_pkg.
//
// Several independent priority queues, each built from one FIFO per priority level.
// A push beat names a queue and a priority (0 counts as 1, above the top level counts
// as the top level); the core stamps it with the next arrival number (1, 2, ...,
// skipping 0 on wrap) and answers status 0 with that number, or status 3 with 0 when
// the FIFO is full or the queue does not exist. A pop beat answers status 1 with the
// oldest number at the highest non-empty level, or status 2 with 0 when the queue is
// empty or does not exist. The core takes one beat at a time: a push passes through
// the address, descriptor-check and output states before it is ready again; a pop
// scans down from the top level, one descriptor read per cycle through the single
// descriptor table port, until it finds a non-empty level or reaches the lowest. A
// beat that names a queue that does not exist goes from the address state straight
// to the output state. The result sits in an output register. When a result waits
// there under stall, the next beat's result holds the core in its last state, so
// the input stalls until the waiting result is taken.
// No clearing pass is needed after reset: descriptors carry per-entry valid bits.
module multi_queue_priority_fifo_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mqpf_pkg::FUNC_BITS-1:0]    i_func,
    input  logic [mqpf_pkg::QSEL_BITS-1:0]    i_queue_select,
    input  logic [mqpf_pkg::PRI_BITS-1:0]     i_priority_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mqpf_pkg::STATUS_BITS-1:0]  o_status,
    output logic [mqpf_pkg::OUT_ID_BITS-1:0]  o_entry_id
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // ready for a beat
    localparam logic [2:0] S_ADDR = 3'd1;  // form FIFO index, read first descriptor
    localparam logic [2:0] S_DCHK = 3'd2;  // examine descriptor, scan or commit
    localparam logic [2:0] S_OUT  = 3'd3;  // hand result to the output register

    logic [2:0] r_state, n_state;

    // latched command
    logic [mqpf_pkg::FUNC_BITS-1:0] r_func;
    logic [mqpf_pkg::QSEL_BITS-1:0] r_qsel;
    logic [mqpf_pkg::PRI_BITS-1:0]  r_pri;

    // scan position
    logic [mqpf_pkg::FIFO_BITS-1:0] r_fifo, n_fifo;
    logic [mqpf_pkg::LVL_BITS-1:0]  r_lvl, n_lvl;

    // pending result
    logic [mqpf_pkg::STATUS_BITS-1:0] r_res_status, n_res_status;
    logic [mqpf_pkg::OUT_ID_BITS-1:0] r_res_id, n_res_id;
    logic                             r_use_store, n_use_store;

    logic [mqpf_pkg::ID_BITS-1:0] r_arrival, n_arrival;

    // output register
    logic                             r_out_valid;
    logic [mqpf_pkg::STATUS_BITS-1:0] r_out_status;
    logic [mqpf_pkg::OUT_ID_BITS-1:0] r_out_id;

    // memory ports
    logic                             w_drd_en;
    logic [mqpf_pkg::FIFO_BITS-1:0]   w_drd_addr;
    mqpf_pkg::t_desc                  w_desc;
    mqpf_pkg::t_desc_wr               w_dwr;
    mqpf_pkg::t_store_wr              w_swr;
    logic                             w_srd_en;
    logic [mqpf_pkg::STORE_ABITS-1:0] w_srd_addr;
    logic [mqpf_pkg::ID_BITS-1:0]     w_srd_data;

    // datapath helpers
    logic                             w_in_acc;
    logic                             w_q_ok;
    logic [mqpf_pkg::LVL_BITS-1:0]    w_push_lvl;
    logic [mqpf_pkg::LVL_BITS-1:0]    w_start_lvl;
    logic [mqpf_pkg::FIFO_BITS-1:0]   w_base;
    logic [mqpf_pkg::CNT_BITS:0]      w_tail_sum;
    logic [mqpf_pkg::PTR_BITS-1:0]    w_tail;
    logic [mqpf_pkg::PTR_BITS-1:0]    w_head_inc;
    logic [mqpf_pkg::ID_BITS-1:0]     w_arr_inc;
    logic                             w_full;
    logic                             w_out_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // queue range check and priority clamp
    assign w_q_ok = (32'(r_qsel) < mqpf_pkg::NUM_QUEUES);

    always_comb begin
        if (r_pri == '0) begin
            w_push_lvl = '0;
        end else if (32'(r_pri) > mqpf_pkg::NUM_LEVELS) begin
            w_push_lvl = mqpf_pkg::LVL_BITS'(mqpf_pkg::NUM_LEVELS - 1);
        end else begin
            w_push_lvl = mqpf_pkg::LVL_BITS'(r_pri - 1'b1);
        end
    end

    // pops start the scan at the top level
    assign w_start_lvl = (r_func == mqpf_pkg::FUNC_POP) ?
                         mqpf_pkg::LVL_BITS'(mqpf_pkg::NUM_LEVELS - 1) : w_push_lvl;
    assign w_base = mqpf_pkg::FIFO_BITS'(32'(r_qsel) * mqpf_pkg::NUM_LEVELS
                                         + 32'(w_start_lvl));

    // tail slot: head + count stays below twice the depth, so one subtract wraps it
    assign w_tail_sum = {1'b0, mqpf_pkg::CNT_BITS'(w_desc.head)} + {1'b0, w_desc.count};
    assign w_tail = (32'(w_tail_sum) >= mqpf_pkg::LIST_DEPTH) ?
                    mqpf_pkg::PTR_BITS'(32'(w_tail_sum) - mqpf_pkg::LIST_DEPTH) :
                    mqpf_pkg::PTR_BITS'(w_tail_sum);
    assign w_head_inc = (32'(w_desc.head) == mqpf_pkg::LIST_DEPTH - 1) ?
                        '0 : w_desc.head + 1'b1;
    assign w_full = (32'(w_desc.count) >= mqpf_pkg::LIST_DEPTH);

    // arrival number skips zero on wrap
    assign w_arr_inc = ((r_arrival + 1'b1) == '0) ?
                       mqpf_pkg::ID_BITS'(1) : r_arrival + 1'b1;

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_fifo       = r_fifo;
        n_lvl        = r_lvl;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_use_store  = r_use_store;
        n_arrival    = r_arrival;
        w_drd_en     = 1'b0;
        w_drd_addr   = r_fifo - 1'b1;
        w_dwr        = '0;
        w_swr        = '0;
        w_srd_en     = 1'b0;
        w_srd_addr   = mqpf_pkg::STORE_ABITS'(32'(r_fifo) * mqpf_pkg::LIST_DEPTH
                                              + 32'(w_desc.head));
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_use_store = 1'b0;
                if (w_q_ok) begin
                    // fetch the first descriptor
                    w_drd_en   = 1'b1;
                    w_drd_addr = w_base;
                    n_fifo     = w_base;
                    n_lvl      = w_start_lvl;
                    n_state    = S_DCHK;
                end else begin
                    n_res_status = (r_func == mqpf_pkg::FUNC_POP) ?
                                   mqpf_pkg::ST_EMPTY : mqpf_pkg::ST_REJECT;
                    n_res_id     = '0;
                    n_state      = S_OUT;
                end
            end
            S_DCHK: begin
                if (r_func == mqpf_pkg::FUNC_PUSH) begin
                    n_state = S_OUT;
                    if (w_full) begin
                        n_res_status = mqpf_pkg::ST_REJECT;
                        n_res_id     = '0;
                    end else begin
                        // append at the tail, advance the fill level
                        n_arrival        = w_arr_inc;
                        w_swr.en         = 1'b1;
                        w_swr.addr       = mqpf_pkg::STORE_ABITS'(
                                               32'(r_fifo) * mqpf_pkg::LIST_DEPTH
                                               + 32'(w_tail));
                        w_swr.data       = w_arr_inc;
                        w_dwr.en         = 1'b1;
                        w_dwr.addr       = r_fifo;
                        w_dwr.desc.head  = w_desc.head;
                        w_dwr.desc.count = w_desc.count + 1'b1;
                        n_res_status     = mqpf_pkg::ST_PUSH_OK;
                        n_res_id         = mqpf_pkg::to_out_id(w_arr_inc);
                    end
                end else if (w_desc.count != '0) begin
                    // take the head entry; its number arrives from the store next cycle
                    w_srd_en         = 1'b1;
                    w_dwr.en         = 1'b1;
                    w_dwr.addr       = r_fifo;
                    w_dwr.desc.head  = w_head_inc;
                    w_dwr.desc.count = w_desc.count - 1'b1;
                    n_res_status     = mqpf_pkg::ST_POP_OK;
                    n_use_store      = 1'b1;
                    n_state          = S_OUT;
                end else if (r_lvl == '0) begin
                    n_res_status = mqpf_pkg::ST_EMPTY;
                    n_res_id     = '0;
                    n_state      = S_OUT;
                end else begin
                    // level empty: read the next lower one
                    w_drd_en = 1'b1;
                    n_fifo   = r_fifo - 1'b1;
                    n_lvl    = r_lvl - 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arrival   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_arrival <= n_arrival;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= i_func;
            r_qsel <= i_queue_select;
            r_pri  <= i_priority_req;
        end
        r_fifo       <= n_fifo;
        r_lvl        <= n_lvl;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_use_store  <= n_use_store;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_use_store ? mqpf_pkg::to_out_id(w_srd_data) : r_res_id;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_entry_id  = r_out_id;

    mqpf_desc_mem u_desc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_drd_en),
        .i_rd_addr (w_drd_addr),
        .o_rd_desc (w_desc),
        .i_wr      (w_dwr)
    );

    mqpf_entry_mem u_store (
        .i_clk     (i_clk),
        .i_wr      (w_swr),
        .i_rd_en   (w_srd_en),
        .i_rd_addr (w_srd_addr),
        .o_rd_data (w_srd_data)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for multi_queue_priority_fifo_core.
// Needs the core RTL and mqpf_pkg for port widths, function and status codes.
`timescale 1ns / 1ps

module tb_top;
    import mqpf_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int TAIL_CYCLES = 32;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [OUT_ID_BITS-1:0] entry_id;
    } result_t;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic [FUNC_BITS-1:0]   i_func         = FUNC_PUSH;
    logic [QSEL_BITS-1:0]   i_queue_select = '0;
    logic [PRI_BITS-1:0]    i_priority_req = '0;
    logic                   i_out_stall    = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [STATUS_BITS-1:0] o_status;
    logic [OUT_ID_BITS-1:0] o_entry_id;

    // Shadow copy of the queue storage
    logic [ID_BITS-1:0]  shadow_store [STORE_DEPTH];
    logic [PTR_BITS-1:0] shadow_head  [FIFO_COUNT];
    logic [CNT_BITS-1:0] shadow_fill  [FIFO_COUNT];
    logic [ID_BITS-1:0]  shadow_last_id;

    result_t pending_results[$];
    result_t last_prediction;

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int stall_hold_left  = 0;
    int beats_sent       = 0;
    int results_checked  = 0;
    int rejects_seen     = 0;
    int empties_seen     = 0;
    int error_count      = 0;
    int cycle_count      = 0;

    multi_queue_priority_fifo_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_queue_select (i_queue_select),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_entry_id     (o_entry_id)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: give up well past the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Count down a long receiver hold-off once one is armed.
    always @(posedge i_clk) begin
        if (stall_hold_left != 0) begin
            stall_hold_left <= stall_hold_left - 1;
        end
    end

    // Drive the result-side stall: forced during a hold-off, random otherwise.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("tb_top: MISMATCH %s", msg);
        error_count++;
    endtask

    // Compare every result beat against the oldest prediction.
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d id %0d",
                                          o_status, o_entry_id));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                              results_checked, want.status, o_status));
                end
                if (o_entry_id !== want.entry_id) begin
                    report_mismatch($sformatf("result %0d entry_id: expected %0d, got %0d",
                                              results_checked, want.entry_id, o_entry_id));
                end
                if (want.status == ST_REJECT) rejects_seen++;
                if (want.status == ST_EMPTY) empties_seen++;
            end
            results_checked++;
        end
    end

    // Work out the answer to one beat and advance the shadow queues.
    function automatic result_t predict_queue_op(input logic [FUNC_BITS-1:0] f,
                                                 input logic [QSEL_BITS-1:0] q,
                                                 input logic [PRI_BITS-1:0]  p);
        result_t            r;
        int                 lvl;
        int                 fifo;
        int                 slot;
        bit                 found;
        logic [ID_BITS-1:0] next_id;
        r.status   = ST_EMPTY;
        r.entry_id = '0;
        found      = 1'b0;
        if (f == FUNC_PUSH) begin
            r.status = ST_REJECT;
            if (q < NUM_QUEUES) begin
                // Clamp the priority into the level range.
                if (p == 0) lvl = 0;
                else if (p > NUM_LEVELS) lvl = NUM_LEVELS - 1;
                else lvl = p - 1;
                fifo = q * NUM_LEVELS + lvl;
                if (shadow_fill[fifo] < LIST_DEPTH) begin
                    next_id = shadow_last_id + 1'b1;
                    if (next_id == '0) next_id = 1;
                    shadow_last_id = next_id;
                    slot = (shadow_head[fifo] + shadow_fill[fifo]) % LIST_DEPTH;
                    shadow_store[fifo * LIST_DEPTH + slot] = next_id;
                    shadow_fill[fifo] = shadow_fill[fifo] + 1'b1;
                    r.status   = ST_PUSH_OK;
                    r.entry_id = OUT_ID_BITS'(next_id);
                end
            end
        end else if (q < NUM_QUEUES) begin
            // Scan from the top level down; the first non-empty FIFO answers.
            for (lvl = NUM_LEVELS - 1; lvl >= 0; lvl--) begin
                fifo = q * NUM_LEVELS + lvl;
                if (!found && shadow_fill[fifo] != 0) begin
                    found = 1'b1;
                    r.status   = ST_POP_OK;
                    r.entry_id = OUT_ID_BITS'(shadow_store[fifo * LIST_DEPTH
                                                           + shadow_head[fifo]]);
                    shadow_head[fifo] = shadow_head[fifo] + 1'b1;
                    shadow_fill[fifo] = shadow_fill[fifo] - 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Offer one beat, hold it until taken, then queue its prediction.
    task automatic send_beat(input logic [FUNC_BITS-1:0] f,
                             input logic [QSEL_BITS-1:0] q,
                             input logic [PRI_BITS-1:0]  p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_queue_select <= q;
        i_priority_req <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        last_prediction = predict_queue_op(f, q, p);
        pending_results.push_back(last_prediction);
        beats_sent++;
    endtask

    // Mostly legal commands, a hot spot that fills FIFOs, and some noise.
    task automatic send_random_beat();
        int                   pick;
        logic [FUNC_BITS-1:0] f;
        logic [QSEL_BITS-1:0] q;
        logic [PRI_BITS-1:0]  p;
        pick = $urandom_range(99);
        if (pick < 15) begin
            f = FUNC_BITS'($urandom_range(1));
            q = QSEL_BITS'($urandom_range(7));
            p = PRI_BITS'($urandom_range(15));
        end else if (pick < 35) begin
            f = ($urandom_range(99) < 75) ? FUNC_PUSH : FUNC_POP;
            q = '0;
            p = PRI_BITS'($urandom_range(NUM_LEVELS, NUM_LEVELS - 1));
        end else begin
            f = ($urandom_range(99) < 55) ? FUNC_PUSH : FUNC_POP;
            q = QSEL_BITS'($urandom_range(NUM_QUEUES - 1));
            p = PRI_BITS'($urandom_range(NUM_LEVELS, 1));
        end
        send_beat(f, q, p);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Empty pops, out-of-range queues, priority clamping and FIFO order.
    task automatic test_basic_ops();
        send_beat(FUNC_POP,  3'd0, 4'd0);
        send_beat(FUNC_POP,  3'd7, 4'd15);
        send_beat(FUNC_PUSH, 3'd5, 4'd5);
        send_beat(FUNC_PUSH, 3'd7, 4'd15);
        send_beat(FUNC_PUSH, 3'd0, 4'd0);
        send_beat(FUNC_PUSH, 3'd0, 4'd15);
        send_beat(FUNC_PUSH, 3'd0, 4'd10);
        send_beat(FUNC_PUSH, 3'd0, 4'd1);
        send_beat(FUNC_PUSH, 3'd4, 4'd5);
        repeat (5) send_beat(FUNC_POP, 3'd0, 4'd0);
        send_beat(FUNC_POP,  3'd4, 4'd0);
        wait_drain();
    endtask

    // Fill one FIFO, push past full, then free a slot and reuse it.
    task automatic test_full_fifo();
        repeat (LIST_DEPTH) send_beat(FUNC_PUSH, 3'd3, 4'd7);
        send_beat(FUNC_PUSH, 3'd3, 4'd7);
        send_beat(FUNC_POP,  3'd3, 4'd0);
        send_beat(FUNC_PUSH, 3'd3, 4'd7);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_beat();
        wait_drain();
    endtask

    // Hold the result side off long enough that the core backs up its input.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        stall_hold_left <= HOLD_CYCLES;
        repeat (40) send_random_beat();
        wait_drain();
    endtask

    // Empty one queue, refill one level and pop it dry plus one.
    task automatic test_fifo_order();
        set_idling(0, 0);
        send_beat(FUNC_POP, 3'd2, 4'd0);
        while (last_prediction.status != ST_EMPTY) send_beat(FUNC_POP, 3'd2, 4'd0);
        repeat (8) send_beat(FUNC_PUSH, 3'd2, 4'd3);
        repeat (9) send_beat(FUNC_POP,  3'd2, 4'd0);
        wait_drain();
    endtask

    initial begin
        foreach (shadow_head[i]) begin
            shadow_head[i] = '0;
            shadow_fill[i] = '0;
        end
        shadow_last_id = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(16, 72);
        test_basic_ops();
        test_full_fifo();
        test_random_traffic(120);
        set_idling(72, 16);
        test_random_traffic(120);
        set_idling(0, 0);
        test_random_traffic(120);
        test_output_backpressure();
        test_fifo_order();

        // Let any stray beat surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("tb_top: %0d beats, %0d results checked (%0d rejects, %0d empty pops)",
                 beats_sent, results_checked, rejects_seen, empties_seen);
        $display("tb_top: covered clamping, full FIFOs, bad queues, hold-off, level order");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/mqpf_pkg.sv
design/mqpf_desc_mem.sv
design/mqpf_entry_mem.sv
design/multi_queue_priority_fifo_core.sv
test/tb_top.sv
